// ===== sv/pchb_pkg.sv =====
// pchb_pkg: shared types and constants for the polyline conform height blend.
// Used by pchb_ctrl, pchb_dp and the top level; depends on nothing.
package pchb_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int T_BITS         = 16;
  localparam logic [16:0] T_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] CFG_MARGIN     = 2'd1;
  localparam logic [1:0] CFG_FALLOFF    = 2'd2;

  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = 16;
  localparam int SQ_STEPS  = 35;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CAPT, OP_LDA, OP_LDB, OP_DIFF,
    OP_MDX, OP_MDY, OP_MQX, OP_MQY, OP_DOT, OP_DIVT, OP_DSTEP,
    OP_MCX, OP_MCY, OP_MCZ, OP_MEX, OP_MEY, OP_SQSUM, OP_CMP,
    OP_SQI, OP_SQSTEP, OP_DIVU, OP_MUU, OP_MS, OP_ALPHA, OP_MB,
    OP_BLEND, OP_OUT
  } op_t;

  typedef struct packed {
    logic need_blend;   // vertex lies in the falloff zone
  } sts_t;

endpackage

// ===== sv/pchb_dp.sv =====
// pchb_dp: point tables, shared multiplier, divider, square root and blend.
// Depends on pchb_pkg; driven by op codes from pchb_ctrl.
module pchb_dp
  import pchb_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  input  logic [AW-1:0]      rd_addr,
  input  logic [AW-1:0]      wr_addr,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output sts_t               sts,
  output logic signed [31:0] blended_z,
  output logic signed [31:0] road_z,
  output logic [31:0]        nearest_distance,
  output logic               touched
);

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [31:0] mem_z [MAX_POINTS];
  logic signed [31:0] rd_x, rd_y, rd_z;

  logic [30:0] half_width, margin, falloff;

  logic signed [31:0] px, py, pz, ax, ay, az, bx, by, bz;
  logic signed [32:0] dx, dy, dz, qx, qy;
  logic signed [34:0] ex, ey;
  logic signed [69:0] prod, len, dot, rem, den, dsq, best;
  logic [16:0]        quo, alpha;
  logic               div_run, have;
  logic signed [31:0] road_c, best_road, blend_res;
  logic [69:0]        sq_val;
  logic [37:0]        sq_rem;
  logic [35:0]        root;

  logic signed [34:0] ma, mb;
  logic [31:0]        core;
  logic [32:0]        total;
  logic               in_total, in_core;
  logic signed [69:0] num_i, den_i, r2;
  logic [39:0]        sq_s, sq_trial;
  logic [17:0]        kpoly;
  logic [69:0]        s_full;
  logic [37:0]        s_val;

  function automatic logic signed [69:0] scale_t(input logic signed [69:0] v);
    return (v + 70'sd32768) >>> T_BITS;
  endfunction

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      mem_x[wr_addr] <= pos_x;
      mem_y[wr_addr] <= pos_y;
      mem_z[wr_addr] <= pos_z;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_z <= mem_z[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= '0;
      margin     <= '0;
      falloff    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HALF_WIDTH: half_width <= cfg_data;
        CFG_MARGIN:     margin     <= cfg_data;
        CFG_FALLOFF:    falloff    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign core     = {1'b0, half_width} + {1'b0, margin};
  assign total    = {1'b0, core} + {2'b0, falloff};
  assign in_total = root <= {3'b0, total};
  assign in_core  = root <= {4'b0, core};
  assign sts.need_blend = have && in_total && !in_core && (falloff != '0);

  assign kpoly = 18'(3 * T_ONE) - {quo, 1'b0};

  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      OP_MDX: begin ma = 35'(dx); mb = 35'(dx); end
      OP_MDY: begin ma = 35'(dy); mb = 35'(dy); end
      OP_MQX: begin ma = 35'(qx); mb = 35'(dx); end
      OP_MQY: begin ma = 35'(qy); mb = 35'(dy); end
      OP_MCX: begin ma = 35'(dx); mb = $signed({18'd0, quo}); end
      OP_MCY: begin ma = 35'(dy); mb = $signed({18'd0, quo}); end
      OP_MCZ: begin ma = 35'(dz); mb = $signed({18'd0, quo}); end
      OP_MEX: begin ma = ex; mb = ex; end
      OP_MEY: begin ma = ey; mb = ey; end
      OP_MUU: begin ma = $signed({18'd0, quo}); mb = $signed({18'd0, quo}); end
      OP_MS:  begin ma = $signed({1'b0, prod[33:0]}); mb = $signed({17'd0, kpoly}); end
      OP_MB:  begin ma = 35'(best_road) - 35'(pz); mb = $signed({18'd0, alpha}); end
      default: ;
    endcase
  end

  // divider operands: projection (dot / len) or falloff position
  always_comb begin
    if (op == OP_DIVU) begin
      num_i = $signed({34'd0, root}) - $signed({38'd0, core});
      den_i = $signed({39'd0, falloff});
    end else begin
      num_i = dot;
      den_i = len;
    end
  end

  assign r2       = rem <<< 1;
  assign sq_s     = {sq_rem, sq_val[69:68]};
  assign sq_trial = {2'b0, root, 2'b01};
  assign s_full   = prod + 70'sd2147483648;
  assign s_val    = s_full[69:32];

  always_ff @(posedge clk) begin
    if (op == OP_MDX || op == OP_MDY || op == OP_MQX || op == OP_MQY ||
        op == OP_MCX || op == OP_MCY || op == OP_MCZ || op == OP_MEX ||
        op == OP_MEY || op == OP_MUU || op == OP_MS  || op == OP_MB) begin
      prod <= ma * mb;
    end
    case (op)
      OP_CAPT: begin
        px <= pos_x; py <= pos_y; pz <= pos_z;
        have <= 1'b0;
      end
      OP_LDA: begin ax <= rd_x; ay <= rd_y; az <= rd_z; end
      OP_LDB: begin bx <= rd_x; by <= rd_y; bz <= rd_z; end
      OP_DIFF: begin
        dx <= 33'(bx) - 33'(ax);
        dy <= 33'(by) - 33'(ay);
        dz <= 33'(bz) - 33'(az);
        qx <= 33'(px) - 33'(ax);
        qy <= 33'(py) - 33'(ay);
      end
      OP_MDY:   len <= prod;
      OP_MQX:   len <= len + prod;
      OP_MQY:   dot <= prod;
      OP_DOT:   dot <= dot + prod;
      OP_DIVT, OP_DIVU: begin
        rem <= num_i;
        den <= den_i;
        if (den_i == '0 || num_i <= 0) begin
          quo <= '0; div_run <= 1'b0;
        end else if (num_i >= den_i) begin
          quo <= T_ONE; div_run <= 1'b0;
        end else begin
          quo <= '0; div_run <= 1'b1;
        end
      end
      OP_DSTEP: begin
        if (div_run) begin
          if (r2 >= den) begin
            rem <= r2 - den; quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= r2;       quo <= {quo[15:0], 1'b0};
          end
        end
      end
      OP_MCY:   ex <= 35'(px) - 35'(ax) - 35'(scale_t(prod));
      OP_MCZ:   ey <= 35'(py) - 35'(ay) - 35'(scale_t(prod));
      OP_MEX:   road_c <= 32'(70'(az) + scale_t(prod));
      OP_MEY:   dsq <= prod;
      OP_SQSUM: dsq <= dsq + prod;
      OP_CMP: begin
        if (!have || dsq < best) begin
          have <= 1'b1; best <= dsq; best_road <= road_c;
        end
        ax <= bx; ay <= by; az <= bz;
      end
      OP_SQI: begin
        sq_val <= best; sq_rem <= '0; root <= '0;
      end
      OP_SQSTEP: begin
        if (sq_s >= sq_trial) begin
          sq_rem <= 38'(sq_s - sq_trial); root <= {root[34:0], 1'b1};
        end else begin
          sq_rem <= 38'(sq_s);            root <= {root[34:0], 1'b0};
        end
        sq_val <= sq_val << 2;
      end
      OP_ALPHA: alpha <= (s_val > 38'(T_ONE)) ? 17'd0 : T_ONE - s_val[16:0];
      OP_BLEND: blend_res <= 32'(70'(pz) + scale_t(prod));
      OP_OUT: begin
        if (!have) begin
          blended_z <= pz; road_z <= '0;
          nearest_distance <= '1; touched <= 1'b0;
        end else begin
          road_z  <= best_road;
          touched <= in_total;
          nearest_distance <= (root[35:32] != '0) ? '1 : root[31:0];
          if (sts.need_blend)  blended_z <= blend_res;
          else if (in_total)   blended_z <= best_road;
          else                 blended_z <= pz;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pchb_ctrl.sv =====
// pchb_ctrl: sequencer for loads, the segment walk and the final blend.
// Depends on pchb_pkg; issues op codes and table addresses to pchb_dp.
module pchb_ctrl
  import pchb_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS),
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          kind,
  input  logic          start_new,
  input  sts_t          sts,
  output logic          busy,
  output logic          done,
  output op_t           op,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  typedef enum logic [29:0] {
    S_IDLE  = 30'h00000001, S_READA = 30'h00000002, S_LOADA = 30'h00000004,
    S_READB = 30'h00000008, S_LOADB = 30'h00000010, S_DIFF  = 30'h00000020,
    S_MDX   = 30'h00000040, S_MDY   = 30'h00000080, S_MQX   = 30'h00000100,
    S_MQY   = 30'h00000200, S_DOT   = 30'h00000400, S_DIVI  = 30'h00000800,
    S_DIV   = 30'h00001000, S_MCX   = 30'h00002000, S_MCY   = 30'h00004000,
    S_MCZ   = 30'h00008000, S_MEX   = 30'h00010000, S_MEY   = 30'h00020000,
    S_SQS   = 30'h00040000, S_CMP   = 30'h00080000, S_SQI   = 30'h00100000,
    S_SQ    = 30'h00200000, S_CHK   = 30'h00400000, S_DIVU  = 30'h00800000,
    S_MUU   = 30'h01000000, S_MS    = 30'h02000000, S_MA    = 30'h04000000,
    S_MB    = 30'h08000000, S_BL    = 30'h10000000, S_OUT   = 30'h20000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0]    count;
  logic [AW-1:0]    seg;
  logic [CNT_W-1:0] cnt;
  logic             fin;
  logic             accept, last_seg;

  assign accept   = start && !busy;
  assign busy     = state != S_IDLE;
  assign last_seg = {{(CW-AW){1'b0}}, seg} == count - CW'(2);
  assign rd_addr  = (state == S_READA) ? '0 : seg + AW'(1);
  assign wr_addr  = start_new ? '0 : count[AW-1:0];

  always_comb begin
    state_next = state;
    op = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (accept && !kind) begin
          if (start_new || count < CW'(MAX_POINTS)) op = OP_LOAD;
        end else if (accept) begin
          op = OP_CAPT;
          state_next = (count < CW'(2)) ? S_OUT : S_READA;
        end
      end
      S_READA: state_next = S_LOADA;
      S_LOADA: begin op = OP_LDA; state_next = S_LOADB; end
      S_READB: state_next = S_LOADB;
      S_LOADB: begin op = OP_LDB; state_next = S_DIFF; end
      S_DIFF:  begin op = OP_DIFF; state_next = S_MDX; end
      S_MDX:   begin op = OP_MDX; state_next = S_MDY; end
      S_MDY:   begin op = OP_MDY; state_next = S_MQX; end
      S_MQX:   begin op = OP_MQX; state_next = S_MQY; end
      S_MQY:   begin op = OP_MQY; state_next = S_DOT; end
      S_DOT:   begin op = OP_DOT; state_next = S_DIVI; end
      S_DIVI:  begin op = OP_DIVT; state_next = S_DIV; end
      S_DIV: begin
        op = OP_DSTEP;
        if (cnt == '0) state_next = fin ? S_MUU : S_MCX;
      end
      S_MCX:   begin op = OP_MCX; state_next = S_MCY; end
      S_MCY:   begin op = OP_MCY; state_next = S_MCZ; end
      S_MCZ:   begin op = OP_MCZ; state_next = S_MEX; end
      S_MEX:   begin op = OP_MEX; state_next = S_MEY; end
      S_MEY:   begin op = OP_MEY; state_next = S_SQS; end
      S_SQS:   begin op = OP_SQSUM; state_next = S_CMP; end
      S_CMP:   begin op = OP_CMP; state_next = last_seg ? S_SQI : S_READB; end
      S_SQI:   begin op = OP_SQI; state_next = S_SQ; end
      S_SQ: begin
        op = OP_SQSTEP;
        if (cnt == '0) state_next = S_CHK;
      end
      S_CHK:   state_next = sts.need_blend ? S_DIVU : S_OUT;
      S_DIVU:  begin op = OP_DIVU; state_next = S_DIV; end
      S_MUU:   begin op = OP_MUU; state_next = S_MS; end
      S_MS:    begin op = OP_MS; state_next = S_MA; end
      S_MA:    begin op = OP_ALPHA; state_next = S_MB; end
      S_MB:    begin op = OP_MB; state_next = S_BL; end
      S_BL:    begin op = OP_BLEND; state_next = S_OUT; end
      S_OUT:   begin op = OP_OUT; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      seg   <= '0;
      cnt   <= '0;
      fin   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_OUT;
      if (op == OP_LOAD) count <= start_new ? CW'(1) : count + CW'(1);
      if (op == OP_CAPT) begin
        seg <= '0;
        fin <= 1'b0;
      end
      if (state == S_CMP && !last_seg) seg <= seg + AW'(1);
      if (state == S_DIVI || state == S_DIVU) cnt <= CNT_W'(DIV_STEPS - 1);
      else if (state == S_SQI) cnt <= CNT_W'(SQ_STEPS - 1);
      else if (cnt != '0) cnt <= cnt - CNT_W'(1);
      if (state == S_CHK) fin <= 1'b1;
    end
  end

endmodule

// ===== sv/polyline_conform_height_blend_core.sv =====
// polyline_conform_height_blend_core: top level, controller plus datapath.
// Depends on pchb_pkg, pchb_ctrl and pchb_dp.
//
// Usage
//  - Requests enter on start/busy: a request is taken at a clock edge with
//    start high and busy low. kind=0 stores a road point (start_new first
//    clears the polyline); kind=1 queries a terrain vertex.
//  - A point load gives no result; busy stays low.
//  - A query walks every stored segment, one at a time, through one shared
//    35x35 multiplier and a 1-bit/cycle divider. Then a 35-step square root,
//    check and output and, in the falloff zone, a second 16-step division
//    and the smoothstep blend.
//  - With fewer than two points a query skips the walk and goes straight to
//    output.
//  - Results show on blended_z/road_z/nearest_distance/touched for the one
//    cycle that done is high, right after busy drops; the receiver cannot
//    stall, so nothing waits.
//  - Config: cfg_we/cfg_addr/cfg_data write half width, margin or falloff;
//    user must write while the block is idle (not enforced); index 3 is ignored.
//  - Reset (rst, synchronous) empties the polyline and zeroes the config.
module polyline_conform_height_blend_core
  import pchb_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic               start_new,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [30:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] blended_z,
  output logic signed [31:0] road_z,
  output logic [31:0]        nearest_distance,
  output logic               touched
);

  localparam int AW = $clog2(MAX_POINTS);

  op_t           op;
  sts_t          sts;
  logic [AW-1:0] rd_addr, wr_addr;

  // sequencer: point count, segment index and step counter
  pchb_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst, .start, .kind, .start_new, .sts,
    .busy, .done, .op, .rd_addr, .wr_addr
  );

  // tables, arithmetic and result registers
  pchb_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst, .op, .rd_addr, .wr_addr,
    .cfg_we, .cfg_addr, .cfg_data,
    .pos_x, .pos_y, .pos_z, .sts,
    .blended_z, .road_z, .nearest_distance, .touched
  );

endmodule

// ===== sv/pchb_chk.sv =====
// pchb_chk: port-level checks for the top level, attached by bind.
// Depends only on the top level's ports.
module pchb_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !kind) |=> (!busy && !done))
    else $error("point load did not finish in one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind) |=> busy) else $error("query request not taken");

  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");

endmodule

bind polyline_conform_height_blend_core pchb_chk u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .done(done)
);
